// ===== src/ths_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the terrain height sampler.
// No dependencies; imported by every module of the block except the RAM.
package ths_pkg;

    localparam int MAX_COLS = 256;
    localparam int MAX_ROWS = 256;
    localparam int DEPTH    = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int DIM_W    = 9;
    localparam int POS_W    = 24;
    localparam int INV_W    = 24;
    localparam int PROD_W   = POS_W + INV_W + 1;
    localparam int P_W      = PROD_W - 16;
    localparam int FRAC_W   = 9;

    localparam logic [1:0] CFG_COLS = 2'd0;
    localparam logic [1:0] CFG_ROWS = 2'd1;
    localparam logic [1:0] CFG_INV  = 2'd2;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [DIM_W-1:0] COLS_RESET = DIM_W'(256);
    localparam logic [DIM_W-1:0] ROWS_RESET = DIM_W'(256);
    localparam logic [INV_W-1:0] INV_RESET  = INV_W'(65536);

    // One transaction on its way to the height store
    typedef struct packed {
        logic              func;
        logic              wr_ok;
        logic [7:0]        wheight;
        logic [7:0]        row;
        logic [7:0]        col;
        logic [FRAC_W-1:0] fu;
        logic [FRAC_W-1:0] fv;
        logic              clamped;
        logic [ADDR_W-1:0] addr;
    } ths_item_t;

    typedef struct packed {
        logic [7:0]        row;
        logic [7:0]        col;
        logic [FRAC_W-1:0] fu;
        logic [FRAC_W-1:0] fv;
        logic              clamped;
    } ths_qry_t;

    typedef struct packed {
        logic valid;
        logic cd_now;
    } ths_fctl_t;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
        if (v < DIM_W'(2))
            return DIM_W'(2);
        else if (v > maxv)
            return maxv;
        return v;
    endfunction

endpackage

// ===== src/ths_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module ths_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ths_geom.sv =====
`timescale 1ns / 1ps
// Position-to-cell pipeline: scale, offset, clamp, cell/fraction, store address.
// Depends on ths_pkg.
module ths_geom
    import ths_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    func,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_z,
    input  logic [7:0]              write_row,
    input  logic [7:0]              write_col,
    input  logic [7:0]              write_height,
    input  logic [DIM_W-1:0]        cols,
    input  logic [DIM_W-1:0]        rows,
    input  logic [INV_W-1:0]        inv,
    output logic                    m_valid,
    output ths_item_t               m_item,
    input  logic                    m_ready
);

    localparam int OFF_W = 8 + DIM_W;

    typedef struct packed {
        logic [7:0]        cidx;
        logic [FRAC_W-1:0] frac;
        logic              clp;
    } ths_axis_t;

    function automatic ths_axis_t clamp_axis(input logic signed [P_W-1:0] p,
                                             input logic [DIM_W-1:0] n);
        logic [DIM_W-1:0] nm1;
        logic [DIM_W-1:0] nm2;
        logic [15:0]      lim;
        logic [15:0]      pc;
        logic [7:0]       cidx;
        logic [16:0]      fr;
        ths_axis_t        r;
        nm1   = n - DIM_W'(1);
        nm2   = n - DIM_W'(2);
        lim   = {nm1[7:0], 8'b0};
        r.clp = 1'b0;
        if (p[P_W-1])
        begin
            pc    = '0;
            r.clp = 1'b1;
        end
        else if (p > $signed({{(P_W-16){1'b0}}, lim}))
        begin
            pc    = lim;
            r.clp = 1'b1;
        end
        else
        begin
            pc = p[15:0];
        end
        cidx = pc[15:8];
        if ({1'b0, cidx} > nm2)
        begin
            cidx = nm2[7:0];
        end
        fr     = {1'b0, pc} - {1'b0, cidx, 8'b0};
        r.cidx = cidx;
        r.frac = fr[FRAC_W-1:0];
        return r;
    endfunction

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    logic                     func1_reg, func2_reg;
    logic [7:0]               row1_reg, col1_reg, ht1_reg;
    logic [7:0]               row2_reg, col2_reg, ht2_reg;
    logic                     wok2_reg;
    logic signed [PROD_W-1:0] xp1_reg, zp1_reg, xp1_next, zp1_next;
    logic signed [PROD_W-1:0] offx, offz, sumx, sumz;
    logic signed [P_W-1:0]    px2_reg, pz2_reg;
    logic                     wok2_next;
    ths_axis_t                ax, az;
    ths_item_t                item3_reg, item3_next, item4_reg, item4_next;
    logic [OFF_W-1:0]         rowoff, addr_sum;

    assign rdy4     = !v4_reg || m_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_stall = !rdy1;

    // G1: scale by reciprocal spacing
    assign xp1_next = PROD_W'(pos_x) * PROD_W'($signed({1'b0, inv}));
    assign zp1_next = PROD_W'(pos_z) * PROD_W'($signed({1'b0, inv}));

    // G2: centre on the grid, drop to Q.8
    assign offx      = $signed({{(PROD_W-DIM_W-23){1'b0}}, cols - DIM_W'(1), 23'b0});
    assign offz      = $signed({{(PROD_W-DIM_W-23){1'b0}}, rows - DIM_W'(1), 23'b0});
    assign sumx      = offx + xp1_reg;
    assign sumz      = offz - zp1_reg;
    assign wok2_next = ({1'b0, row1_reg} < rows) && ({1'b0, col1_reg} < cols);

    // G3: clamp, cell and fraction
    always_comb
    begin
        ax                 = clamp_axis(px2_reg, cols);
        az                 = clamp_axis(pz2_reg, rows);
        item3_next.func    = func2_reg;
        item3_next.wr_ok   = wok2_reg;
        item3_next.wheight = ht2_reg;
        item3_next.row     = (func2_reg == FUNC_QUERY) ? az.cidx : row2_reg;
        item3_next.col     = (func2_reg == FUNC_QUERY) ? ax.cidx : col2_reg;
        item3_next.fu      = ax.frac;
        item3_next.fv      = az.frac;
        item3_next.clamped = ax.clp | az.clp;
        item3_next.addr    = '0;
    end

    // G4: row-major store address
    assign rowoff   = OFF_W'(item3_reg.row) * OFF_W'(cols);
    assign addr_sum = rowoff + OFF_W'(item3_reg.col);

    always_comb
    begin
        item4_next      = item3_reg;
        item4_next.addr = addr_sum[ADDR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            func1_reg <= func;
            row1_reg  <= write_row;
            col1_reg  <= write_col;
            ht1_reg   <= write_height;
            xp1_reg   <= xp1_next;
            zp1_reg   <= zp1_next;
        end
        if (rdy2)
        begin
            func2_reg <= func1_reg;
            row2_reg  <= row1_reg;
            col2_reg  <= col1_reg;
            ht2_reg   <= ht1_reg;
            wok2_reg  <= wok2_next;
            px2_reg   <= sumx[PROD_W-1:16];
            pz2_reg   <= sumz[PROD_W-1:16];
        end
        if (rdy3)
        begin
            item3_reg <= item3_next;
        end
        if (rdy4)
        begin
            item4_reg <= item4_next;
        end
    end

    assign m_valid = v4_reg;
    assign m_item  = item4_reg;

endmodule

// ===== src/ths_fetch.sv =====
`timescale 1ns / 1ps
// Height store access: duplicated sample RAMs, write path and two-phase corner reads.
// Depends on ths_pkg and ths_ram.
module ths_fetch
    import ths_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             g_valid,
    input  ths_item_t        g_item,
    output logic             g_ready,
    input  logic [DIM_W-1:0] cols,
    output ths_fctl_t        f_ctl,
    output ths_qry_t         f_qry,
    output logic [7:0]       f_a,
    output logic [7:0]       f_b,
    output logic [7:0]       f_c,
    output logic [7:0]       f_d,
    input  logic             e_ready
);

    localparam logic [1:0] PH_AB   = 2'd0;
    localparam logic [1:0] PH_CD   = 2'd1;
    localparam logic [1:0] PH_HOLD = 2'd2;

    logic [1:0]        ph_reg, ph_next;
    logic [7:0]        a_reg, b_reg;
    logic              we, re;
    logic [ADDR_W-1:0] raddr0, raddr1, addr_c;
    logic [7:0]        rdata0, rdata1;

    assign addr_c = g_item.addr + ADDR_W'(cols);

    always_comb
    begin
        ph_next      = ph_reg;
        g_ready      = 1'b0;
        we           = 1'b0;
        re           = 1'b0;
        raddr0       = g_item.addr;
        raddr1       = g_item.addr + ADDR_W'(1);
        f_ctl.valid  = 1'b0;
        f_ctl.cd_now = 1'b0;
        if (g_valid)
        begin
            if (g_item.func == FUNC_WRITE)
            begin
                we      = g_item.wr_ok;
                g_ready = 1'b1;
            end
            else
            begin
                case (ph_reg)
                    PH_AB:
                    begin
                        re      = 1'b1;
                        ph_next = PH_CD;
                    end
                    PH_CD:
                    begin
                        re          = 1'b1;
                        raddr0      = addr_c;
                        raddr1      = addr_c + ADDR_W'(1);
                        f_ctl.valid = 1'b1;
                        if (e_ready)
                        begin
                            g_ready = 1'b1;
                            ph_next = PH_AB;
                        end
                        else
                        begin
                            ph_next = PH_HOLD;
                        end
                    end
                    PH_HOLD:
                    begin
                        f_ctl.valid  = 1'b1;
                        f_ctl.cd_now = 1'b1;
                        if (e_ready)
                        begin
                            g_ready = 1'b1;
                            ph_next = PH_AB;
                        end
                    end
                    default:
                    begin
                        ph_next = PH_AB;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= PH_AB;
        end
        else
        begin
            ph_reg <= ph_next;
        end
    end

    // held while the next stage is busy; read port idles so C/D stay put
    always_ff @(posedge clk)
    begin
        if (ph_reg == PH_CD)
        begin
            a_reg <= rdata0;
            b_reg <= rdata1;
        end
    end

    ths_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram0 (
        .clk   (clk),
        .we    (we),
        .waddr (g_item.addr),
        .wdata (g_item.wheight),
        .re    (re),
        .raddr (raddr0),
        .rdata (rdata0)
    );

    ths_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram1 (
        .clk   (clk),
        .we    (we),
        .waddr (g_item.addr),
        .wdata (g_item.wheight),
        .re    (re),
        .raddr (raddr1),
        .rdata (rdata1)
    );

    assign f_qry.row     = g_item.row;
    assign f_qry.col     = g_item.col;
    assign f_qry.fu      = g_item.fu;
    assign f_qry.fv      = g_item.fv;
    assign f_qry.clamped = g_item.clamped;
    assign f_a           = (ph_reg == PH_HOLD) ? a_reg : rdata0;
    assign f_b           = (ph_reg == PH_HOLD) ? b_reg : rdata1;
    assign f_c           = rdata0;
    assign f_d           = rdata1;

endmodule

// ===== src/ths_interp.sv =====
`timescale 1ns / 1ps
// Triangle interpolation of the four corner samples and the result register.
// Depends on ths_pkg.
module ths_interp
    import ths_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ths_fctl_t   f_ctl,
    input  ths_qry_t    f_qry,
    input  logic [7:0]  f_a,
    input  logic [7:0]  f_b,
    input  logic [7:0]  f_c,
    input  logic [7:0]  f_d,
    output logic        e_ready,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] height,
    output logic [7:0]  cell_row,
    output logic [7:0]  cell_col,
    output logic        clamped
);

    logic        e_valid_reg, cd_ok_reg, out_valid_reg;
    ths_qry_t    q_reg;
    logic [7:0]  a_reg, b_reg, c_reg, d_reg;
    logic [15:0] height_reg, height_next;
    logic [7:0]  row_reg, col_reg;
    logic        clamped_reg;
    logic        o_ready, fire, load, cd_cap;

    logic                    abc;
    logic [7:0]              base;
    logic [FRAC_W-1:0]       w1, w2;
    logic signed [8:0]       d1, d2;
    logic signed [19:0]      p1, p2, hs;

    assign o_ready = !out_valid_reg || !out_stall;
    assign fire    = e_valid_reg && cd_ok_reg && o_ready;
    assign e_ready = !e_valid_reg || fire;
    assign load    = f_ctl.valid && e_ready;
    assign cd_cap  = load ? f_ctl.cd_now : (e_valid_reg && !cd_ok_reg);

    always_comb
    begin
        abc = ({1'b0, q_reg.fu} + {1'b0, q_reg.fv}) < 10'd256;
        if (abc)
        begin
            base = a_reg;
            w1   = q_reg.fu;
            w2   = q_reg.fv;
            d1   = 9'({1'b0, b_reg}) - 9'({1'b0, a_reg});
            d2   = 9'({1'b0, c_reg}) - 9'({1'b0, a_reg});
        end
        else
        begin
            base = d_reg;
            w1   = 9'd256 - q_reg.fu;
            w2   = 9'd256 - q_reg.fv;
            d1   = 9'({1'b0, c_reg}) - 9'({1'b0, d_reg});
            d2   = 9'({1'b0, b_reg}) - 9'({1'b0, d_reg});
        end
        p1 = 20'($signed({1'b0, w1})) * 20'(d1);
        p2 = 20'($signed({1'b0, w2})) * 20'(d2);
        hs = $signed({4'b0, base, 8'b0}) + p1 + p2;
        if (hs[19])
        begin
            height_next = '0;
        end
        else if (|hs[18:16])
        begin
            height_next = 16'hFFFF;
        end
        else
        begin
            height_next = hs[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg   <= 1'b0;
            cd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                e_valid_reg <= 1'b1;
                cd_ok_reg   <= f_ctl.cd_now;
            end
            else if (fire)
            begin
                e_valid_reg <= 1'b0;
            end
            else if (e_valid_reg && !cd_ok_reg)
            begin
                cd_ok_reg <= 1'b1;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= f_qry;
            a_reg <= f_a;
            b_reg <= f_b;
        end
        if (cd_cap)
        begin
            c_reg <= f_c;
            d_reg <= f_d;
        end
        if (fire)
        begin
            height_reg  <= height_next;
            row_reg     <= q_reg.row;
            col_reg     <= q_reg.col;
            clamped_reg <= q_reg.clamped;
        end
    end

    assign out_valid = out_valid_reg;
    assign height    = height_reg;
    assign cell_row  = row_reg;
    assign cell_col  = col_reg;
    assign clamped   = clamped_reg;

endmodule

// ===== src/terrain_height_sampler_core.sv =====
`timescale 1ns / 1ps
// Top level of the terrain height sampler: configuration registers and stage wiring.
// Depends on ths_pkg, ths_geom, ths_fetch, ths_interp.
//
// Usage:
//   Input channel (in_valid/in_stall): func 0 writes write_height at
//   (write_row, write_col); writes outside the rows/columns in use are dropped
//   and no transaction leaves the output. func 1 queries the height at
//   (pos_x, pos_z) and gives one output transaction (height, cell_row,
//   cell_col, clamped).
//   Queries read their corners in an A/B phase and then a C/D phase over the
//   two read ports of the duplicated height store, which bounds the query rate;
//   one write per cycle while the pipeline does not stall.
//   Items complete in acceptance order; a write is visible to any later query.
//   The user writes configuration (cfg_we/cfg_index/cfg_data) only while idle;
//   the block does not enforce it. Reset: registers return to 256 columns,
//   256 rows, unit spacing; the pipeline empties. Height samples are not
//   cleared and must be written before they are queried.
//   When out_stall is high the result holds; the pipeline keeps filling up to
//   its stages and then raises in_stall.
module terrain_height_sampler_core
    import ths_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [INV_W-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    func,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_z,
    input  logic [7:0]              write_row,
    input  logic [7:0]              write_col,
    input  logic [7:0]              write_height,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [15:0]             height,
    output logic [7:0]              cell_row,
    output logic [7:0]              cell_col,
    output logic                    clamped
);

    logic [DIM_W-1:0] cols_in_use_reg, rows_in_use_reg;
    logic [INV_W-1:0] inv_cell_distance_reg;
    logic [DIM_W-1:0] cols_eff, rows_eff;

    logic       g_valid, g_ready, e_ready;
    ths_item_t  g_item;
    ths_fctl_t  f_ctl;
    ths_qry_t   f_qry;
    logic [7:0] f_a, f_b, f_c, f_d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_in_use_reg       <= COLS_RESET;
            rows_in_use_reg       <= ROWS_RESET;
            inv_cell_distance_reg <= INV_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COLS: cols_in_use_reg       <= cfg_data[DIM_W-1:0];
                CFG_ROWS: rows_in_use_reg       <= cfg_data[DIM_W-1:0];
                CFG_INV:  inv_cell_distance_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    assign cols_eff = eff_dim(cols_in_use_reg, DIM_W'(MAX_COLS));
    assign rows_eff = eff_dim(rows_in_use_reg, DIM_W'(MAX_ROWS));

    ths_geom u_geom (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .pos_x        (pos_x),
        .pos_z        (pos_z),
        .write_row    (write_row),
        .write_col    (write_col),
        .write_height (write_height),
        .cols         (cols_eff),
        .rows         (rows_eff),
        .inv          (inv_cell_distance_reg),
        .m_valid      (g_valid),
        .m_item       (g_item),
        .m_ready      (g_ready)
    );

    ths_fetch u_fetch (
        .clk     (clk),
        .rst_n   (rst_n),
        .g_valid (g_valid),
        .g_item  (g_item),
        .g_ready (g_ready),
        .cols    (cols_eff),
        .f_ctl   (f_ctl),
        .f_qry   (f_qry),
        .f_a     (f_a),
        .f_b     (f_b),
        .f_c     (f_c),
        .f_d     (f_d),
        .e_ready (e_ready)
    );

    ths_interp u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .f_ctl     (f_ctl),
        .f_qry     (f_qry),
        .f_a       (f_a),
        .f_b       (f_b),
        .f_c       (f_c),
        .f_d       (f_d),
        .e_ready   (e_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .height    (height),
        .cell_row  (cell_row),
        .cell_col  (cell_col),
        .clamped   (clamped)
    );

endmodule

// ===== tb/tb_terrain_height_sampler_core.sv =====
`timescale 1ns / 1ps
// Self-checking bench for terrain_height_sampler_core: directed grid, edge and register cases,
// then random sample writes and height queries with random gaps and output stalls.
// Depends on ths_pkg and the terrain_height_sampler_core RTL.
module tb_terrain_height_sampler_core;
    import ths_pkg::*;

    localparam longint CYCLE_LIMIT = 2000000;
    localparam int LATENCY = 7;
    localparam int PHASE_ITEMS = 90;
    localparam int MAX_REPORTS = 200;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [15:0] height;
        logic [7:0]  row;
        logic [7:0]  col;
        logic        clamped;
    } height_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [1:0]              cfg_index = CFG_COLS;
    logic [INV_W-1:0]        cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    func = FUNC_WRITE;
    logic signed [POS_W-1:0] pos_x = '0;
    logic signed [POS_W-1:0] pos_z = '0;
    logic [7:0]              write_row = '0;
    logic [7:0]              write_col = '0;
    logic [7:0]              write_height = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [15:0]             height;
    logic [7:0]              cell_row;
    logic [7:0]              cell_col;
    logic                    clamped;

    // grid copy, addressed like the block's store
    logic [DIM_W-1:0] grid_cols_reg = COLS_RESET;
    logic [DIM_W-1:0] grid_rows_reg = ROWS_RESET;
    logic [INV_W-1:0] grid_inv_reg = INV_RESET;
    bit [7:0]         grid_mem [DEPTH];
    bit               grid_known [DEPTH];

    height_result_t pending_heights [$];

    int     in_gap_mode = 1;
    int     out_stall_mode = 1;
    int     stall_left = 0;
    int     fail_count = 0;
    int     queries_sent = 0;
    int     writes_kept = 0;
    int     writes_dropped = 0;
    int     settings_applied = 0;
    int     results_checked = 0;
    longint cycle_count = 0;

    terrain_height_sampler_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .pos_x        (pos_x),
        .pos_z        (pos_z),
        .write_row    (write_row),
        .write_col    (write_col),
        .write_height (write_height),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .height       (height),
        .cell_row     (cell_row),
        .cell_col     (cell_col),
        .clamped      (clamped)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int dim_in_use(input logic [DIM_W-1:0] v);
        if (v < 2)
            return 2;
        if (v > 256)
            return 256;
        return int'(v);
    endfunction

    function automatic void fold_axis(input longint p, input int n, output int cell_idx,
                                      output int frac, inout bit clp);
        longint lim;
        longint c;
        lim = longint'(n - 1) * 256;
        if (p < 0)
        begin
            p = 0;
            clp = 1'b1;
        end
        else if (p > lim)
        begin
            p = lim;
            clp = 1'b1;
        end
        c = p / 256;
        if (c > n - 2)
            c = n - 2;
        cell_idx = int'(c);
        frac = int'(p - c * 256);
    endfunction

    function automatic height_result_t predict_height(input logic [23:0] x_raw,
                                                      input logic [23:0] z_raw);
        logic signed [23:0] xs;
        logic signed [23:0] zs;
        longint         x, z, px, pz, a, b, c, d, h;
        int             cols, rows, ccol, crow, fu, fv;
        bit             clp;
        height_result_t res;
        xs = x_raw;
        zs = z_raw;
        x = xs;
        z = zs;
        cols = dim_in_use(grid_cols_reg);
        rows = dim_in_use(grid_rows_reg);
        px = ((longint'(cols - 1) <<< 23) + x * longint'(grid_inv_reg)) >>> 16;
        pz = ((longint'(rows - 1) <<< 23) - z * longint'(grid_inv_reg)) >>> 16;
        clp = 1'b0;
        fold_axis(px, cols, ccol, fu, clp);
        fold_axis(pz, rows, crow, fv, clp);
        a = grid_mem[crow * cols + ccol];
        b = grid_mem[crow * cols + ccol + 1];
        c = grid_mem[(crow + 1) * cols + ccol];
        d = grid_mem[(crow + 1) * cols + ccol + 1];
        if (fu + fv < 256)
            h = a * 256 + fu * (b - a) + fv * (c - a);
        else
            h = d * 256 + (256 - fu) * (c - d) + (256 - fv) * (b - d);
        if (h < 0)
            h = 0;
        if (h > 65535)
            h = 65535;
        res.height = h[15:0];
        res.row = crow[7:0];
        res.col = ccol[7:0];
        res.clamped = clp;
        return res;
    endfunction

    function automatic void store_sample(input logic [7:0] r, input logic [7:0] c,
                                         input logic [7:0] h);
        int cols;
        int rows;
        cols = dim_in_use(grid_cols_reg);
        rows = dim_in_use(grid_rows_reg);
        if (r < rows && c < cols)
        begin
            grid_mem[r * cols + c] = h;
            grid_known[r * cols + c] = 1'b1;
            writes_kept++;
        end
        else
            writes_dropped++;
    endfunction

    // none in mode 0; otherwise often none (mostly so in mode 1), some short, a few long
    function automatic int pick_delay(input int mode);
        int r;
        if (mode == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < ((mode == 1) ? 75 : 40))
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_height();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 8'h00;
        if (r < 4)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // world coordinate aimed at a chosen grid position, with some off-grid and wild values
    function automatic logic [23:0] aim_position(input int n, input bit z_axis);
        longint p, t, v;
        int     r;
        r = $urandom_range(0, 99);
        if (r < 8 || grid_inv_reg == 0)
            return 24'($urandom);
        if (r < 18)
            p = ($urandom_range(0, 1) ? longint'(n - 1) * 256 : 0)
                + int'($urandom_range(0, 4)) - 2;
        else if (r < 28)
            p = $urandom_range(0, 1) ? -longint'($urandom_range(1, 4096))
                                     : longint'(n - 1) * 256 + $urandom_range(1, 4096);
        else
            p = $urandom_range(0, (n - 1) * 256);
        t = (p <<< 16) - (longint'(n - 1) <<< 23);
        v = t / longint'(grid_inv_reg);
        if (z_axis)
            v = -v;
        if (v > 8388607)
            v = 8388607;
        if (v < -8388608)
            v = -8388608;
        return v[23:0];
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_monitor
        height_result_t want;
        int             d;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_heights.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $error("result with no query pending: height %0d row %0d col %0d",
                           height, cell_row, cell_col);
            end
            else
            begin
                want = pending_heights.pop_front();
                results_checked++;
                compare_field("height", want.height, height);
                compare_field("cell_row", 16'(want.row), 16'(cell_row));
                compare_field("cell_col", 16'(want.col), 16'(cell_col));
                compare_field("clamped", 16'(want.clamped), 16'(clamped));
            end
        end
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            d = pick_delay(out_stall_mode);
            out_stall <= (d > 0);
            stall_left <= (d > 0) ? d - 1 : 0;
        end
    end

    // valid is left high after acceptance so back-to-back transactions need no toggle
    task automatic push_item(input logic f, input logic [23:0] x, input logic [23:0] z,
                             input logic [7:0] r, input logic [7:0] c, input logic [7:0] h);
        int gap;
        gap = pick_delay(in_gap_mode);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        pos_x <= x;
        pos_z <= z;
        write_row <= r;
        write_col <= c;
        write_height <= h;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (f == FUNC_QUERY)
        begin
            pending_heights = {pending_heights, predict_height(x, z)};
            queries_sent++;
        end
        else
            store_sample(r, c, h);
    endtask

    task automatic send_write(input logic [7:0] r, input logic [7:0] c, input logic [7:0] h);
        push_item(FUNC_WRITE, 24'($urandom), 24'($urandom), r, c, h);
    endtask

    // corners of the cell to be read are written first if still unknown
    task automatic send_query(input logic [23:0] x, input logic [23:0] z);
        height_result_t p;
        int             cols;
        int             rr;
        int             cc;
        p = predict_height(x, z);
        cols = dim_in_use(grid_cols_reg);
        for (rr = 0; rr < 2; rr++)
            for (cc = 0; cc < 2; cc++)
                if (!grid_known[(p.row + rr) * cols + p.col + cc])
                    send_write(8'(p.row + rr), 8'(p.col + cc), pick_height());
        push_item(FUNC_QUERY, x, z, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_heights.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic set_register(input logic [1:0] idx, input logic [23:0] value);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_applied++;
        case (idx)
            CFG_COLS: grid_cols_reg = value[DIM_W-1:0];
            CFG_ROWS: grid_rows_reg = value[DIM_W-1:0];
            CFG_INV:  grid_inv_reg = value;
            default:  ;
        endcase
    endtask

    task automatic test_reset_grid_edges();
        send_write(8'd0, 8'd0, 8'h00);
        send_write(8'd0, 8'd1, 8'hFF);
        send_write(8'd1, 8'd0, 8'hFF);
        send_write(8'd1, 8'd1, 8'h00);
        send_write(8'd255, 8'd255, 8'hFF);
        send_query(-24'sd32640, 24'sd32640);
        send_query(24'sd32640, -24'sd32640);
        send_query(-24'sd32641, 24'sd32640);
        send_query(24'h7FFFFF, 24'h800000);
        send_query(24'h800000, 24'h7FFFFF);
    endtask

    task automatic test_triangle_split();
        send_write(8'd127, 8'd127, 8'hFF);
        send_write(8'd127, 8'd128, 8'h00);
        send_write(8'd128, 8'd127, 8'h00);
        send_write(8'd128, 8'd128, 8'hFF);
        send_query(24'sd0, 24'sd0);
        send_query(-24'sd1, 24'sd0);
        send_query(24'sd0, 24'sd1);
        send_query(24'sd100, -24'sd100);
    endtask

    task automatic test_small_grid_writes();
        int r;
        int c;
        set_register(CFG_COLS, 24'd3);
        set_register(CFG_ROWS, 24'd3);
        for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
                send_write(8'(r), 8'(c), pick_height());
        send_write(8'd3, 8'd0, 8'h5A);
        send_write(8'd0, 8'd3, 8'hA5);
        send_write(8'd255, 8'd255, 8'h00);
        send_write(8'd2, 8'd200, 8'h11);
        send_query(24'sd0, 24'sd0);
        send_query(24'sd256, -24'sd256);
        send_query(24'h800000, 24'h7FFFFF);
    endtask

    task automatic test_register_limits();
        set_register(CFG_COLS, 24'd0);
        set_register(CFG_ROWS, 24'd1);
        send_query(24'sd0, 24'sd0);
        send_query(24'h7FFFFF, 24'h7FFFFF);
        set_register(CFG_COLS, 24'hABC1FF);
        set_register(CFG_ROWS, 24'h000101);
        send_query(aim_position(256, 1'b0), aim_position(256, 1'b1));
        set_register(CFG_UNUSED, 24'h000003);
        send_query(24'sd0, 24'sd0);
        set_register(CFG_INV, 24'd0);
        send_query(24'h7FFFFF, 24'h800000);
        send_query(24'($urandom), 24'($urandom));
        set_register(CFG_INV, 24'hFFFFFF);
        send_query(24'sd16, -24'sd16);
        send_query(aim_position(256, 1'b0), aim_position(256, 1'b1));
        set_register(CFG_INV, INV_RESET);
    endtask

    task automatic test_random_traffic();
        int          ph;
        int          k;
        int          r;
        int          cols;
        int          rows;
        int          cols_set;
        int          rows_set;
        logic [23:0] inv_set;
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:
                begin
                    cols_set = 2;
                    rows_set = 2;
                    inv_set = 24'd65536;
                end
                1:
                begin
                    cols_set = 256;
                    rows_set = 256;
                    inv_set = 24'd65536;
                end
                2:
                begin
                    cols_set = 17;
                    rows_set = 5;
                    inv_set = 24'($urandom_range(4096, 1048576));
                end
                3:
                begin
                    cols_set = 3;
                    rows_set = 200;
                    inv_set = 24'hFFFFFF;
                end
                4:
                begin
                    cols_set = $urandom_range(2, 256);
                    rows_set = $urandom_range(2, 256);
                    inv_set = 24'd1;
                end
                5:
                begin
                    cols_set = 256;
                    rows_set = 2;
                    inv_set = 24'($urandom_range(1, 16777215));
                end
                6:
                begin
                    cols_set = 64;
                    rows_set = 64;
                    inv_set = 24'd300000;
                end
                default:
                begin
                    cols_set = $urandom_range(2, 256);
                    rows_set = $urandom_range(2, 256);
                    inv_set = 24'($urandom_range(1, 16777215));
                end
            endcase
            set_register(CFG_COLS, {15'($urandom), 9'(cols_set)});
            set_register(CFG_ROWS, {15'($urandom), 9'(rows_set)});
            set_register(CFG_INV, inv_set);
            in_gap_mode = ph % 3;
            out_stall_mode = (ph + 1) % 3;
            cols = dim_in_use(grid_cols_reg);
            rows = dim_in_use(grid_rows_reg);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 25)
                    send_write(8'($urandom_range(0, rows - 1)), 8'($urandom_range(0, cols - 1)),
                               pick_height());
                else if (r < 30)
                    send_write(8'($urandom), 8'($urandom), pick_height());
                else
                    send_query(aim_position(cols, 1'b0), aim_position(rows, 1'b1));
            end
        end
        in_gap_mode = 1;
        out_stall_mode = 1;
        settle();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_grid_edges();
        test_triangle_split();
        test_small_grid_writes();
        test_register_limits();
        test_random_traffic();
        settle();
        $display("Run covered %0d queries and %0d sample writes (%0d dropped as off-grid),",
                 queries_sent, writes_kept, writes_dropped);
        $display("across %0d register writes; %0d results compared, %0d mismatches.",
                 settings_applied, results_checked, fail_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
